// ===== rtl/core/resp_command_parser_unit_macros.svh =====
// Assertion macros shared by the parser RTL.
`ifndef RESP_COMMAND_PARSER_UNIT_MACROS_SVH
`define RESP_COMMAND_PARSER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the trigger.
`define RCP_ASSERT_NOW(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("parser assertion failed");

// The consequent must hold in the cycle after the trigger.
`define RCP_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("parser assertion failed");

`endif

// ===== rtl/core/rcp_pkg.sv =====
`timescale 1ns / 1ps

package rcp_pkg;

    // Bytes that carry meaning in the command syntax.
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ARG     = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_NO_STAR    = 3'd0;
    localparam logic [2:0] ERR_ARRAY_LONG = 3'd1;
    localparam logic [2:0] ERR_BAD_COUNT  = 3'd2;
    localparam logic [2:0] ERR_NO_DOLLAR  = 3'd3;
    localparam logic [2:0] ERR_BULK_LONG  = 3'd4;
    localparam logic [2:0] ERR_BAD_LENGTH = 3'd5;
    localparam logic [2:0] ERR_NO_CRLF    = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_ARGS     = 2'd0;
    localparam logic [1:0] CFG_MAX_BULK_LEN = 2'd1;
    localparam logic [1:0] CFG_MAX_LINE_LEN = 2'd2;

    // Reset values of the limits.
    localparam logic [15:0] MAX_ARGS_RESET     = 16'd1024;
    localparam logic [31:0] MAX_BULK_LEN_RESET = 32'd536870912;
    localparam logic [15:0] MAX_LINE_LEN_RESET = 16'd1024;

    // Saturation ceiling of a decimal header value.
    localparam logic [32:0] VALUE_CAP = 33'h1_FFFF_FFFF;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload;
        logic [15:0] arg_index;
        logic        is_null;
        logic        last;
        logic [2:0]  error_code;
    } result_t;

endpackage

// ===== rtl/core/resp_command_parser_unit.sv =====
`timescale 1ns / 1ps

// Byte-serial parser for a RESP client command ('*' count line, then for
// each argument a '$' length line, the payload and CR LF). One byte is
// taken per clock cycle while the result stream does not stall; every
// byte passes an input register and then the parse stage, whose result
// is registered in the output register. The parse stage (one
// multiply-by-ten accumulate on the 33-bit line value and the limit
// compares) sets the clock rate. Bytes that produce no result still wait
// for a free output register. Payload bytes come out one per item; each
// argument ends with an argument-complete item, the final one marked by
// tlast. Any malformed input gives a single error item and the parser then
// waits for the next '*'. The limit registers may be written only while
// the parser is idle.
`include "resp_command_parser_unit_macros.svh"

module resp_command_parser_unit
    import rcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [7:0] payload, [23:8] arg_index,
                                     // [24] is_null, [27:25] error_code,
                                     // [31:28] zero
    output logic [1:0]  m_tuser,     // [1:0] kind
    output logic        m_tlast,     // last
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Parse phases.
    localparam logic [2:0] PH_STAR   = 3'd0;
    localparam logic [2:0] PH_ALINE  = 3'd1;
    localparam logic [2:0] PH_DOLLAR = 3'd2;
    localparam logic [2:0] PH_BLINE  = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CR     = 3'd5;
    localparam logic [2:0] PH_LF     = 3'd6;

    // Limits.
    logic [15:0] max_args_reg;
    logic [31:0] max_bulk_len_reg;
    logic [15:0] max_line_len_reg;

    // Input stage.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // Parse state.
    logic [2:0]  phase_reg, phase_next;
    logic [32:0] line_value_reg, line_value_next;
    logic        line_negative_reg, line_negative_next;
    logic        line_has_digit_reg, line_has_digit_next;
    logic        line_invalid_reg, line_invalid_next;
    logic        cr_pending_reg, cr_pending_next;
    logic [16:0] line_length_reg, line_length_next;
    logic [15:0] args_expected_reg, args_expected_next;
    logic [15:0] args_done_reg, args_done_next;
    logic [31:0] bytes_left_reg, bytes_left_next;

    // Output stage.
    logic        out_valid_reg;
    result_t     out_reg;

    logic        advance;
    logic        res_valid;
    result_t     res;
    logic        do_clear;

    // Helpers for the current byte.
    logic [7:0]  b;
    logic        is_digit;
    logic [36:0] value_mul;
    logic [32:0] value_acc;
    logic [16:0] line_len_inc;
    logic        line_too_long;
    logic        first_too_long;
    logic [16:0] arg_idx_inc;
    logic        arg_last;
    logic        line_ok;
    logic        line_neg;
    logic [2:0]  long_code;

    assign cfg_ready = 1'b1;

    // The parse stage moves when the output register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign b              = in_byte_reg;
    assign is_digit       = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign value_mul      = ({4'b0, line_value_reg} << 3) + ({4'b0, line_value_reg} << 1)
                            + {33'b0, b[3:0]};
    assign value_acc      = (value_mul > {4'b0, VALUE_CAP}) ? VALUE_CAP : value_mul[32:0];
    assign line_len_inc   = line_length_reg + 17'd1;
    assign line_too_long  = line_len_inc > {1'b0, max_line_len_reg};
    assign first_too_long = (max_line_len_reg == 16'd0);
    assign arg_idx_inc    = {1'b0, args_done_reg} + 17'd1;
    assign arg_last       = arg_idx_inc >= {1'b0, args_expected_reg};
    assign line_ok        = !line_invalid_reg && line_has_digit_reg;
    assign line_neg       = line_negative_reg && (line_value_reg != 33'd0);
    assign long_code      = (phase_reg == PH_ALINE) ? ERR_ARRAY_LONG : ERR_BULK_LONG;

    // Next parse state and result for the byte in the input register.
    always_comb
    begin
        phase_next          = phase_reg;
        line_value_next     = line_value_reg;
        line_negative_next  = line_negative_reg;
        line_has_digit_next = line_has_digit_reg;
        line_invalid_next   = line_invalid_reg;
        cr_pending_next     = cr_pending_reg;
        line_length_next    = line_length_reg;
        args_expected_next  = args_expected_reg;
        args_done_next      = args_done_reg;
        bytes_left_next     = bytes_left_reg;
        res_valid           = 1'b0;
        res                 = '0;
        do_clear            = 1'b0;

        unique case (phase_reg) inside
            PH_ALINE, PH_BLINE:
            begin
                if (b == CHAR_LF && cr_pending_reg)
                begin
                    // A complete header line.
                    if (phase_reg == PH_ALINE)
                    begin
                        if (!line_ok || line_neg ||
                            line_value_reg > {17'b0, max_args_reg})
                        begin
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.arg_index  = args_done_reg;
                            res.error_code = ERR_BAD_COUNT;
                            do_clear       = 1'b1;
                        end
                        else if (line_value_reg == 33'd0)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_EMPTY;
                            res.last  = 1'b1;
                            do_clear  = 1'b1;
                        end
                        else
                        begin
                            args_expected_next = line_value_reg[15:0];
                            args_done_next     = 16'd0;
                            phase_next         = PH_DOLLAR;
                        end
                    end
                    else if (!line_ok || (line_neg && line_value_reg != 33'd1) ||
                             (!line_neg && line_value_reg > {1'b0, max_bulk_len_reg}))
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.arg_index  = args_done_reg;
                        res.error_code = ERR_BAD_LENGTH;
                        do_clear       = 1'b1;
                    end
                    else if (line_neg)
                    begin
                        // Null bulk string: the argument ends at once.
                        res_valid     = 1'b1;
                        res.kind      = KIND_ARG;
                        res.arg_index = args_done_reg;
                        res.is_null   = 1'b1;
                        res.last      = arg_last;
                        if (arg_last)
                        begin
                            do_clear = 1'b1;
                        end
                        else
                        begin
                            args_done_next = arg_idx_inc[15:0];
                            phase_next     = PH_DOLLAR;
                        end
                    end
                    else
                    begin
                        bytes_left_next = line_value_reg[31:0];
                        phase_next = (line_value_reg[31:0] != 32'd0) ? PH_DATA : PH_CR;
                    end
                end
                else
                begin
                    // A content byte of the header line.
                    line_invalid_next = line_invalid_reg || cr_pending_reg;
                    if (b == CHAR_CR)
                    begin
                        cr_pending_next = 1'b1;
                    end
                    else
                    begin
                        cr_pending_next = 1'b0;
                        if (b == CHAR_MINUS && line_length_reg == 17'd1)
                        begin
                            line_negative_next = 1'b1;
                        end
                        else if (is_digit)
                        begin
                            line_value_next     = value_acc;
                            line_has_digit_next = 1'b1;
                        end
                        else
                        begin
                            line_invalid_next = 1'b1;
                        end
                    end
                    line_length_next = line_len_inc;
                    if (line_too_long)
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.arg_index  = args_done_reg;
                        res.error_code = long_code;
                        do_clear       = 1'b1;
                    end
                end
            end
            PH_DOLLAR:
            begin
                if (b != CHAR_DOLLAR || first_too_long)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.arg_index  = args_done_reg;
                    res.error_code = (b != CHAR_DOLLAR) ? ERR_NO_DOLLAR : ERR_BULK_LONG;
                    do_clear       = 1'b1;
                end
                else
                begin
                    phase_next          = PH_BLINE;
                    line_value_next     = 33'd0;
                    line_negative_next  = 1'b0;
                    line_has_digit_next = 1'b0;
                    line_invalid_next   = 1'b0;
                    cr_pending_next     = 1'b0;
                    line_length_next    = 17'd1;
                end
            end
            PH_DATA:
            begin
                res_valid       = 1'b1;
                res.kind        = KIND_PAYLOAD;
                res.payload     = b;
                res.arg_index   = args_done_reg;
                bytes_left_next = bytes_left_reg - 32'd1;
                if (bytes_left_reg == 32'd1)
                begin
                    phase_next = PH_CR;
                end
            end
            PH_CR:
            begin
                if (b != CHAR_CR)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.arg_index  = args_done_reg;
                    res.error_code = ERR_NO_CRLF;
                    do_clear       = 1'b1;
                end
                else
                begin
                    phase_next = PH_LF;
                end
            end
            PH_LF:
            begin
                res_valid     = 1'b1;
                res.arg_index = args_done_reg;
                if (b != CHAR_LF)
                begin
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_NO_CRLF;
                    do_clear       = 1'b1;
                end
                else
                begin
                    res.kind = KIND_ARG;
                    res.last = arg_last;
                    if (arg_last)
                    begin
                        do_clear = 1'b1;
                    end
                    else
                    begin
                        args_done_next = arg_idx_inc[15:0];
                        phase_next     = PH_DOLLAR;
                    end
                end
            end
            default:
            begin
                // Waiting for the array star; unused codes land here too.
                if (b != CHAR_STAR || first_too_long)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.arg_index  = args_done_reg;
                    res.error_code = (b != CHAR_STAR) ? ERR_NO_STAR : ERR_ARRAY_LONG;
                    do_clear       = 1'b1;
                end
                else
                begin
                    phase_next          = PH_ALINE;
                    line_value_next     = 33'd0;
                    line_negative_next  = 1'b0;
                    line_has_digit_next = 1'b0;
                    line_invalid_next   = 1'b0;
                    cr_pending_next     = 1'b0;
                    line_length_next    = 17'd1;
                end
            end
        endcase

        // End of a command or an error: back to waiting for a star.
        if (do_clear)
        begin
            phase_next          = PH_STAR;
            line_value_next     = 33'd0;
            line_negative_next  = 1'b0;
            line_has_digit_next = 1'b0;
            line_invalid_next   = 1'b0;
            cr_pending_next     = 1'b0;
            line_length_next    = 17'd0;
            args_expected_next  = 16'd0;
            args_done_next      = 16'd0;
            bytes_left_next     = 32'd0;
        end
    end

    // Limit registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_args_reg     <= MAX_ARGS_RESET;
            max_bulk_len_reg <= MAX_BULK_LEN_RESET;
            max_line_len_reg <= MAX_LINE_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_ARGS:     max_args_reg     <= cfg_data[15:0];
                CFG_MAX_BULK_LEN: max_bulk_len_reg <= cfg_data;
                CFG_MAX_LINE_LEN: max_line_len_reg <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_STAR;
            line_value_reg     <= 33'd0;
            line_negative_reg  <= 1'b0;
            line_has_digit_reg <= 1'b0;
            line_invalid_reg   <= 1'b0;
            cr_pending_reg     <= 1'b0;
            line_length_reg    <= 17'd0;
            args_expected_reg  <= 16'd0;
            args_done_reg      <= 16'd0;
            bytes_left_reg     <= 32'd0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            line_value_reg     <= line_value_next;
            line_negative_reg  <= line_negative_next;
            line_has_digit_reg <= line_has_digit_next;
            line_invalid_reg   <= line_invalid_next;
            cr_pending_reg     <= cr_pending_next;
            line_length_reg    <= line_length_next;
            args_expected_reg  <= args_expected_next;
            args_done_reg      <= args_done_next;
            bytes_left_reg     <= bytes_left_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.error_code, out_reg.is_null, out_reg.arg_index,
                       out_reg.payload};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    // A payload item never carries an error code, a null mark or tlast.
    `RCP_ASSERT_NOW(a_payload_clean, clk, rst_n,
        out_valid_reg && out_reg.kind == KIND_PAYLOAD,
        out_reg.error_code == ERR_NO_STAR && !out_reg.is_null && !out_reg.last)

    // An empty command is argument zero and closes the command.
    `RCP_ASSERT_NOW(a_empty_last, clk, rst_n,
        out_valid_reg && out_reg.kind == KIND_EMPTY,
        out_reg.arg_index == 16'd0 && out_reg.last)

    // An error or a final item returns the parser to waiting for a star.
    `RCP_ASSERT_NEXT(a_clear_after_end, clk, rst_n,
        advance && res_valid && (res.kind == KIND_ERROR || res.last),
        phase_reg == PH_STAR && args_done_reg == 16'd0)

    // Arguments completed never reach the announced count mid-command.
    `RCP_ASSERT_NOW(a_args_in_range, clk, rst_n,
        phase_reg == PH_DOLLAR || phase_reg == PH_DATA || phase_reg == PH_CR,
        args_done_reg < args_expected_reg)

endmodule
